// ----- design/icf_pkg.sv -----
// ----------------------------------------------------------------------------
// icf_pkg
// Shared widths, register map, reset values and the CORDIC arctangent table
// of the IMU complementary attitude filter.
// ----------------------------------------------------------------------------
package icf_pkg;

	localparam int ANGLE_FRAC = 16;
	localparam int CORDIC_ITER_DEF = 16;
	localparam int MAX_CAL_DEF = 1024;

	localparam int ANG_W = 28;       // CORDIC vector and angle width
	localparam int SUM_W = 43;       // calibration sums, offsets and rates
	localparam int DIV_NUM_W = 42;
	localparam int DIV_DEN_W = 16;
	localparam int MUL_A_W = 64;
	localparam int MUL_B_W = 17;
	localparam int SQ_IN_W = 48;
	localparam int SQ_OUT_W = 24;
	localparam int CNT_W = 11;
	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_ALPHA = 3'd0;
	localparam logic [2:0] REG_PERIOD = 3'd1;
	localparam logic [2:0] REG_GYRO_SENS = 3'd2;
	localparam logic [2:0] REG_DEADZONE = 3'd3;
	localparam logic [2:0] REG_CAL_SAMPLES = 3'd4;

	localparam logic [15:0] ALPHA_RST = 16'd62915;
	localparam logic [15:0] PERIOD_RST = 16'd655;
	localparam logic [15:0] GYRO_SENS_RST = 16'd16768;
	localparam logic [15:0] DEADZONE_RST = 16'd384;
	localparam logic [10:0] CAL_SAMPLES_RST = 11'd100;

	localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 <<< ANGLE_FRAC);

	localparam int ATAN_SHIFT = 24 - ANGLE_FRAC;
	localparam int ATAN_DEPTH = 24;

	// atan(2^-i) in degrees with 24 fraction bits.
	localparam logic [29:0] ATAN_Q24 [ATAN_DEPTH] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
		30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
		30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
		30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229, 30'd115
	};

	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] i);
		logic [29:0] t;
		t = (i < 5'(ATAN_DEPTH)) ? ATAN_Q24[i] : 30'd0;
		return ANG_W'((t + 30'((1 << ATAN_SHIFT) >> 1)) >> ATAN_SHIFT);
	endfunction

	function automatic logic [16:0] abs17(input logic [15:0] v);
		return v[15] ? (~{v[15], v} + 17'd1) : {1'b0, v};
	endfunction

endpackage

// ----- design/icf_if.sv -----
// ----------------------------------------------------------------------------
// icf_if
// Valid/ready channels of the attitude filter: raw sample in, attitude out.
// ----------------------------------------------------------------------------
interface icf_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;

	modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		output ready);
endinterface

interface icf_attitude_if;
	logic valid;
	logic ready;
	logic signed [31:0] roll_deg;
	logic signed [31:0] pitch_deg;
	logic signed [31:0] yaw_deg;
	logic is_calibrated;

	modport source (output valid, roll_deg, pitch_deg, yaw_deg, is_calibrated,
		input ready);
	modport sink (input valid, roll_deg, pitch_deg, yaw_deg, is_calibrated,
		output ready);
endinterface

// ----- design/imu_complementary_attitude.sv -----
// ----------------------------------------------------------------------------
// imu_complementary_attitude
// Roll, pitch and yaw from raw six-axis IMU samples with startup calibration
// and a complementary filter.
//
// Usage: one raw sample beat enters on the sample channel; one attitude beat
// leaves on the attitude channel for every sample. The block works on one
// sample at a time and holds sample.ready low while it is busy. During
// calibration each sample passes two squarings, a square root, two CORDIC
// runs and three rate divisions; the sample that ends calibration adds
// five divisions. In the running phase the same steps are followed by six
// multiplications for the roll and pitch blend and one for yaw, which is
// skipped when yaw stays inside the deadzone. The next sample can be taken
// in the cycle after the beat is loaded. The finished beat sits in an output
// register; a stalled receiver holds it there, the next sample may already
// be taken and worked on, and the block then waits with sample.ready low
// until the register is free. Reset clears all angles, sums and the
// calibration count, loads the register defaults and starts a new
// calibration. Registers must be written over the APB port only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module imu_complementary_attitude #(
	parameter int CORDIC_ITERATIONS = icf_pkg::CORDIC_ITER_DEF,
	parameter int MAX_CALIBRATION_SAMPLES = icf_pkg::MAX_CAL_DEF
) (
	input  logic clk,
	input  logic arst_n,
	icf_sample_if.sink sample,
	icf_attitude_if.source attitude,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [icf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import icf_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_SQA   = 14'b00000000000010,
		S_SQB   = 14'b00000000000100,
		S_SQRT  = 14'b00000000001000,
		S_CRD_R = 14'b00000000010000,
		S_CRD_P = 14'b00000000100000,
		S_RATE  = 14'b00000001000000,
		S_UPD   = 14'b00000010000000,
		S_CPRE  = 14'b00000100000000,
		S_CDIV  = 14'b00001000000000,
		S_RPRE  = 14'b00010000000000,
		S_STEP  = 14'b00100000000000,
		S_MIX   = 14'b01000000000000,
		S_FIN   = 14'b10000000000000
	} state_t;

	// Configuration registers.
	logic [15:0] alpha_q, period_q, gsens_q, dzone_q;
	logic [10:0] cal_samples_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			period_q <= PERIOD_RST;
			gsens_q <= GYRO_SENS_RST;
			dzone_q <= DEADZONE_RST;
			cal_samples_q <= CAL_SAMPLES_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_ALPHA: alpha_q <= pwdata[15:0];
				REG_PERIOD: period_q <= pwdata[15:0];
				REG_GYRO_SENS: gsens_q <= pwdata[15:0];
				REG_DEADZONE: dzone_q <= pwdata[15:0];
				REG_CAL_SAMPLES: cal_samples_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ALPHA: prdata = {16'd0, alpha_q};
			REG_PERIOD: prdata = {16'd0, period_q};
			REG_GYRO_SENS: prdata = {16'd0, gsens_q};
			REG_DEADZONE: prdata = {16'd0, dzone_q};
			REG_CAL_SAMPLES: prdata = {21'd0, cal_samples_q};
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] sat41(input logic signed [SUM_W:0] v);
		if (v > ((SUM_W+1)'(1) <<< 40) - 1) return (SUM_W'(1) <<< 40) - 1;
		if (v < -((SUM_W+1)'(1) <<< 40)) return -(SUM_W'(1) <<< 40);
		return v[SUM_W-1:0];
	endfunction

	function automatic logic signed [63:0] round16(input logic signed [63:0] v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	// Units.
	logic mul_go_q, div_go_q, sq_go_q, crd_go_q;
	logic signed [MUL_A_W-1:0] mul_a_q, mul_p;
	logic [MUL_B_W-1:0] mul_b_q;
	logic [DIV_NUM_W-1:0] div_num_q, div_quo;
	logic [DIV_DEN_W-1:0] div_den_q;
	logic div_neg_q;
	logic [SQ_IN_W-1:0] sq_rad_q;
	logic [SQ_OUT_W-1:0] sq_root;
	logic signed [ANG_W-1:0] crd_x_q, crd_y_q, crd_z;
	logic mul_done, div_done, sq_done, crd_done;

	icf_mul u_mul (.clk, .arst_n, .start(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .p(mul_p));
	icf_div u_div (.clk, .arst_n, .start(div_go_q), .num(div_num_q), .den(div_den_q),
		.done(div_done), .quo(div_quo));
	icf_sqrt u_sqrt (.clk, .arst_n, .start(sq_go_q), .rad(sq_rad_q),
		.done(sq_done), .root(sq_root));
	icf_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (.clk, .arst_n, .start(crd_go_q),
		.x(crd_x_q), .y(crd_y_q), .done(crd_done), .z(crd_z));

	// Sequencer state and data.
	state_t state_q;
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [31:0] mag_q;
	logic signed [ANG_W-1:0] tilt_q [2];
	logic signed [SUM_W-1:0] rate_q [3];
	logic signed [SUM_W-1:0] cal_q [5];     // roll/pitch offsets, three rate biases
	logic signed [31:0] ang_q [3];          // roll, pitch, yaw
	logic [CNT_W-1:0] count_q;
	logic caldone_q;
	logic [2:0] idx_q;
	logic signed [63:0] v_q;
	logic mix_q;
	logic out_load;

	logic [1:0] rate_idx;
	logic signed [16:0] raw_sel;
	logic [16:0] raw_mag;
	logic [15:0] den_eff;
	logic [CNT_W-1:0] count_n, lim;
	logic signed [SUM_W-1:0] cal_s, cal_mag, div_res;
	logic signed [63:0] step, yr64, dz64;
	logic [1:0] ax2;

	always_comb begin
		rate_idx = (state_q == S_CRD_P) ? 2'd0 : 2'(idx_q + 3'd1);
		case (rate_idx)
			2'd0: raw_sel = -17'(gy_q);
			2'd1: raw_sel = -17'(gx_q);
			default: raw_sel = 17'(gz_q);
		endcase
		raw_mag = raw_sel[16] ? 17'(-raw_sel) : 17'(raw_sel);
		den_eff = (gsens_q == 16'd0) ? 16'd1 : gsens_q;

		count_n = count_q + 1'b1;
		if (cal_samples_q == '0) begin
			lim = CNT_W'(1);
		end else if (13'(cal_samples_q) > 13'(MAX_CALIBRATION_SAMPLES)) begin
			lim = CNT_W'(MAX_CALIBRATION_SAMPLES);
		end else begin
			lim = cal_samples_q;
		end

		cal_s = cal_q[idx_q];
		cal_mag = cal_s[SUM_W-1] ? -cal_s : cal_s;
		div_res = div_neg_q ? -SUM_W'(div_quo) : SUM_W'(div_quo);

		step = round16(mul_p);
		ax2 = idx_q[1:0];
		yr64 = 64'(rate_q[2]);
		dz64 = 64'({dzone_q, 8'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			sq_go_q <= 1'b0;
			crd_go_q <= 1'b0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			div_num_q <= '0;
			div_den_q <= '0;
			div_neg_q <= 1'b0;
			sq_rad_q <= '0;
			crd_x_q <= '0;
			crd_y_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			az_q <= '0;
			gx_q <= '0;
			gy_q <= '0;
			gz_q <= '0;
			mag_q <= '0;
			tilt_q <= '{default: '0};
			rate_q <= '{default: '0};
			cal_q <= '{default: '0};
			ang_q <= '{default: '0};
			count_q <= '0;
			caldone_q <= 1'b0;
			idx_q <= '0;
			v_q <= '0;
			mix_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			sq_go_q <= 1'b0;
			crd_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						ax_q <= sample.accel_x;
						ay_q <= sample.accel_y;
						az_q <= sample.accel_z;
						gx_q <= sample.gyro_x;
						gy_q <= sample.gyro_y;
						gz_q <= sample.gyro_z;
						mul_a_q <= MUL_A_W'(abs17(sample.accel_x));
						mul_b_q <= abs17(sample.accel_x);
						mul_go_q <= 1'b1;
						state_q <= S_SQA;
					end
				end
				S_SQA: begin
					if (mul_done) begin
						mag_q <= mul_p[31:0];
						mul_a_q <= MUL_A_W'(abs17(az_q));
						mul_b_q <= abs17(az_q);
						mul_go_q <= 1'b1;
						state_q <= S_SQB;
					end
				end
				S_SQB: begin
					if (mul_done) begin
						sq_rad_q <= {(mag_q + mul_p[31:0]), 16'd0};
						sq_go_q <= 1'b1;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						crd_x_q <= ANG_W'(az_q) <<< 8;
						crd_y_q <= -(ANG_W'(ax_q) <<< 8);
						crd_go_q <= 1'b1;
						state_q <= S_CRD_R;
					end
				end
				S_CRD_R: begin
					if (crd_done) begin
						tilt_q[0] <= crd_z;
						crd_x_q <= ANG_W'(sq_root);
						crd_y_q <= ANG_W'(ay_q) <<< 8;
						crd_go_q <= 1'b1;
						state_q <= S_CRD_P;
					end
				end
				S_CRD_P: begin
					if (crd_done) begin
						tilt_q[1] <= crd_z;
						idx_q <= '0;
						div_num_q <= {1'b0, raw_mag, 24'd0} + DIV_NUM_W'(den_eff >> 1);
						div_den_q <= den_eff;
						div_neg_q <= raw_sel[16];
						div_go_q <= 1'b1;
						state_q <= S_RATE;
					end
				end
				S_RATE: begin
					if (div_done) begin
						rate_q[idx_q[1:0]] <= div_res;
						if (idx_q == 3'd2) begin
							state_q <= S_UPD;
						end else begin
							idx_q <= idx_q + 3'd1;
							div_num_q <= {1'b0, raw_mag, 24'd0} + DIV_NUM_W'(den_eff >> 1);
							div_den_q <= den_eff;
							div_neg_q <= raw_sel[16];
							div_go_q <= 1'b1;
						end
					end
				end
				S_UPD: begin
					idx_q <= '0;
					if (!caldone_q) begin
						// Sums wrap at 42 bits.
						cal_q[0] <= SUM_W'($signed((cal_q[0] + SUM_W'(tilt_q[0])) << 1)) >>> 1;
						cal_q[1] <= SUM_W'($signed((cal_q[1] + SUM_W'(tilt_q[1])) << 1)) >>> 1;
						cal_q[2] <= SUM_W'($signed((cal_q[2] + rate_q[0]) << 1)) >>> 1;
						cal_q[3] <= SUM_W'($signed((cal_q[3] + rate_q[1]) << 1)) >>> 1;
						cal_q[4] <= SUM_W'($signed((cal_q[4] + rate_q[2]) << 1)) >>> 1;
						count_q <= count_n;
						state_q <= (count_n >= lim) ? S_CPRE : S_FIN;
					end else begin
						rate_q[0] <= sat41((SUM_W+1)'(rate_q[0]) - (SUM_W+1)'(cal_q[2]));
						rate_q[1] <= sat41((SUM_W+1)'(rate_q[1]) - (SUM_W+1)'(cal_q[3]));
						rate_q[2] <= sat41((SUM_W+1)'(rate_q[2]) - (SUM_W+1)'(cal_q[4]));
						state_q <= S_RPRE;
					end
				end
				S_CPRE: begin
					div_num_q <= DIV_NUM_W'(cal_mag) + DIV_NUM_W'(count_q >> 1);
					div_den_q <= DIV_DEN_W'(count_q);
					div_neg_q <= cal_s[SUM_W-1];
					div_go_q <= 1'b1;
					state_q <= S_CDIV;
				end
				S_CDIV: begin
					if (div_done) begin
						cal_q[idx_q] <= div_res;
						if (idx_q == 3'd4) begin
							caldone_q <= 1'b1;
							ang_q <= '{default: '0};
							state_q <= S_FIN;
						end else begin
							idx_q <= idx_q + 3'd1;
							state_q <= S_CPRE;
						end
					end
				end
				S_RPRE: begin
					if (idx_q == 3'd2) begin
						// Yaw integrates only outside the deadzone.
						if (yr64 > dz64 || yr64 < -dz64) begin
							mul_a_q <= yr64;
							mul_b_q <= MUL_B_W'(period_q);
							mul_go_q <= 1'b1;
							state_q <= S_STEP;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						mul_a_q <= MUL_A_W'(rate_q[ax2]);
						mul_b_q <= MUL_B_W'(period_q);
						mul_go_q <= 1'b1;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (mul_done) begin
						if (idx_q == 3'd2) begin
							ang_q[2] <= sat32(64'(ang_q[2]) + step);
							state_q <= S_FIN;
						end else begin
							mul_a_q <= 64'(ang_q[ax2]) + step;
							mul_b_q <= MUL_B_W'(alpha_q);
							mul_go_q <= 1'b1;
							state_q <= S_MIX;
						end
					end
				end
				S_MIX: begin
					if (mul_done) begin
						if (!mix_q) begin
							// Gyro term done; now the accelerometer term.
							v_q <= mul_p;
							mul_a_q <= 64'(tilt_q[ax2[0]]) - 64'(cal_q[ax2]);
							mul_b_q <= 17'h10000 - MUL_B_W'(alpha_q);
							mul_go_q <= 1'b1;
							mix_q <= 1'b1;
						end else begin
							ang_q[ax2] <= sat32(round16(v_q + mul_p));
							idx_q <= idx_q + 3'd1;
							mix_q <= 1'b0;
							state_q <= S_RPRE;
						end
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register.
	logic ov_q;
	logic signed [31:0] roll_q, pitch_q, yaw_q;
	logic calib_q;

	assign out_load = (state_q == S_FIN) && (!ov_q || attitude.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			roll_q <= '0;
			pitch_q <= '0;
			yaw_q <= '0;
			calib_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
			roll_q <= ang_q[0];
			pitch_q <= ang_q[1];
			yaw_q <= ang_q[2];
			calib_q <= caldone_q;
		end else if (attitude.ready) begin
			ov_q <= 1'b0;
		end
	end

	assign sample.ready = (state_q == S_IDLE);
	assign attitude.valid = ov_q;
	assign attitude.roll_deg = roll_q;
	assign attitude.pitch_deg = pitch_q;
	assign attitude.yaw_deg = yaw_q;
	assign attitude.is_calibrated = calib_q;
endmodule

// ----- design/icf_mul.sv -----
// ----------------------------------------------------------------------------
// icf_mul
// Shift-add multiplier: signed 64-bit multiplicand times unsigned 17-bit
// multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module icf_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [icf_pkg::MUL_A_W-1:0] a,
	input  logic [icf_pkg::MUL_B_W-1:0] b,
	output logic done,
	output logic signed [icf_pkg::MUL_A_W-1:0] p
);
	import icf_pkg::*;

	logic signed [MUL_A_W-1:0] acc_q, a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [$clog2(MUL_B_W)-1:0] cnt_q;
	logic busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			a_q <= '0;
			b_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				acc_q <= '0;
				a_q <= a;
				b_q <= b;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q <= a_q <<< 1;
				b_q <= b_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(MUL_B_W))'(MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign p = acc_q;
endmodule

// ----- design/icf_div.sv -----
// ----------------------------------------------------------------------------
// icf_div
// Restoring divider for unsigned operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module icf_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [icf_pkg::DIV_NUM_W-1:0] num,
	input  logic [icf_pkg::DIV_DEN_W-1:0] den,
	output logic done,
	output logic [icf_pkg::DIV_NUM_W-1:0] quo
);
	import icf_pkg::*;

	localparam int CW = $clog2(DIV_NUM_W);

	logic [DIV_DEN_W-1:0] rem_q, den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DIV_DEN_W:0] trial, diff;
	logic fits;

	always_comb begin
		trial = {rem_q, quo_q[DIV_NUM_W-1]};
		diff = trial - {1'b0, den_q};
		fits = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			den_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				den_q <= den;
				quo_q <= num;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
				quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule

// ----- design/icf_sqrt.sv -----
// ----------------------------------------------------------------------------
// icf_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module icf_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [icf_pkg::SQ_IN_W-1:0] rad,
	output logic done,
	output logic [icf_pkg::SQ_OUT_W-1:0] root
);
	import icf_pkg::*;

	localparam int CW = $clog2(SQ_OUT_W);

	logic [SQ_IN_W-1:0] rem_q, r_q, bit_q, sum;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;

	assign sum = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			r_q <= '0;
			bit_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= rad;
				r_q <= '0;
				bit_q <= SQ_IN_W'(1) << (SQ_IN_W - 2);
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (rem_q >= sum) begin
					rem_q <= rem_q - sum;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SQ_OUT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = r_q[SQ_OUT_W-1:0];
endmodule

// ----- design/icf_cordic.sv -----
// ----------------------------------------------------------------------------
// icf_cordic
// Vectoring CORDIC atan2 in degrees, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module icf_cordic #(
	parameter int ITER = icf_pkg::CORDIC_ITER_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [icf_pkg::ANG_W-1:0] x,
	input  logic signed [icf_pkg::ANG_W-1:0] y,
	output logic done,
	output logic signed [icf_pkg::ANG_W-1:0] z
);
	import icf_pkg::*;

	logic signed [ANG_W-1:0] x_q, y_q, z_q, sx, sy, at;
	logic [4:0] i_q;
	logic zero_q, busy_q, done_q;

	always_comb begin
		sx = x_q >>> i_q;
		sy = y_q >>> i_q;
		at = atan_entry(i_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			i_q <= '0;
			zero_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				zero_q <= (x == '0) && (y == '0);
				// A vector in the left half plane is first turned by half a revolution.
				if (x[ANG_W-1]) begin
					x_q <= -x;
					y_q <= -y;
					z_q <= y[ANG_W-1] ? -DEG180 : DEG180;
				end else begin
					x_q <= x;
					y_q <= y;
					z_q <= '0;
				end
				i_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!y_q[ANG_W-1]) begin
					x_q <= x_q + sy;
					y_q <= y_q - sx;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - sy;
					y_q <= y_q + sx;
					z_q <= z_q - at;
				end
				i_q <= i_q + 1'b1;
				if (i_q == 5'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign z = zero_q ? '0 : z_q;
endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the IMU complementary attitude filter. Raw six-axis samples
// are driven through the sample channel with random gaps. An attitude
// predictor in the scoreboard computes every expected beat bit for bit: the
// calibration sums, the CORDIC tilt angles and the complementary blend. Each
// attitude beat is checked against it field by field. The registers are
// written over APB between phases, including their extreme values.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import icf_pkg::*;

	typedef struct {
		logic signed [15:0] ax, ay, az, gx, gy, gz;
	} imu_sample_t;

	typedef struct {
		logic signed [31:0] roll, pitch, yaw;
		logic cal;
	} attitude_t;

	localparam int FRAC = 16;
	localparam int SAMPLE_LIMIT = 1024;

	class attitude_scoreboard;
		int unsigned alpha, period, sens, deadzone, cal_limit;
		longint roll_ang, pitch_ang, yaw_ang;
		longint roll_ofs, pitch_ofs, roll_bias, pitch_bias, yaw_bias;
		int unsigned count;
		bit calibrated;
		attitude_t pending[$];
		int errors;

		function new();
			alpha = ALPHA_RST;
			period = PERIOD_RST;
			sens = GYRO_SENS_RST;
			deadzone = DEADZONE_RST;
			cal_limit = CAL_SAMPLES_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, int unsigned v);
			case (idx)
				REG_ALPHA: begin
					alpha = v & 16'hFFFF;
				end
				REG_PERIOD: begin
					period = v & 16'hFFFF;
				end
				REG_GYRO_SENS: begin
					sens = v & 16'hFFFF;
				end
				REG_DEADZONE: begin
					deadzone = v & 16'hFFFF;
				end
				REG_CAL_SAMPLES: begin
					cal_limit = v & 11'h7FF;
				end
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint sat41(longint v);
			return clamp(v, -(64'sd1 <<< 40), (64'sd1 <<< 40) - 1);
		endfunction

		function longint sat32(longint v);
			return clamp(v, -64'sd2147483648, 64'sd2147483647);
		endfunction

		function longint rnd_shift(longint v, int s);
			return (v + (64'sd1 <<< (s - 1))) >>> s;
		endfunction

		function longint wrap42(longint v);
			return (v <<< 22) >>> 22;
		endfunction

		function longint div_nearest(longint n, longint d);
			longint m;
			m = n < 0 ? -n : n;
			m = (m + d / 2) / d;
			return n < 0 ? -m : m;
		endfunction

		function longint int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return longint'(r);
		endfunction

		function longint arctan2(longint y, longint x);
			longint z, nx, ny, t;
			int n;
			z = 0;
			n = CORDIC_ITER_DEF > 24 ? 24 : CORDIC_ITER_DEF;
			if (x == 0 && y == 0)
				return 0;
			// Left half plane: rotate by half a turn first.
			if (x < 0) begin
				z = (y >= 0) ? (64'sd180 <<< FRAC) : -(64'sd180 <<< FRAC);
				x = -x;
				y = -y;
			end
			for (int i = 0; i < n; i++) begin
				t = (longint'(ATAN_Q24[i]) + (64'sd1 <<< (24 - FRAC - 1))) >>> (24 - FRAC);
				if (y >= 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z = z + t;
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z = z - t;
				end
				x = nx;
				y = ny;
			end
			return z;
		endfunction

		function longint gyro_rate(longint raw);
			longint gs;
			gs = sens != 0 ? longint'(sens) : 1;
			return sat41(div_nearest(raw * (64'sd1 <<< (8 + FRAC)), gs));
		endfunction

		function longint blend(longint ang, longint rate, longint acc);
			longint step, v;
			step = rnd_shift(rate * longint'(period), 16);
			v = longint'(alpha) * (ang + step) + longint'(65536 - alpha) * acc;
			return sat32(rnd_shift(v, 16));
		endfunction

		function void note(imu_sample_t s);
			longint ax, ay, az, roll_acc, pitch_acc, rr, pr, yr, dz, n;
			longint unsigned mag2;
			int unsigned lim;
			attitude_t e;
			ax = s.ax;
			ay = s.ay;
			az = s.az;
			mag2 = longint'(ax * ax + az * az) << 16;
			roll_acc = arctan2(-ax * 256, az * 256);
			pitch_acc = arctan2(ay * 256, int_sqrt(mag2));
			rr = gyro_rate(-longint'(s.gy));
			pr = gyro_rate(-longint'(s.gx));
			yr = gyro_rate(longint'(s.gz));
			if (!calibrated) begin
				lim = cal_limit == 0 ? 1 : cal_limit;
				if (lim > SAMPLE_LIMIT)
					lim = SAMPLE_LIMIT;
				roll_ofs = wrap42(roll_ofs + roll_acc);
				pitch_ofs = wrap42(pitch_ofs + pitch_acc);
				roll_bias = wrap42(roll_bias + rr);
				pitch_bias = wrap42(pitch_bias + pr);
				yaw_bias = wrap42(yaw_bias + yr);
				count++;
				if (count >= lim) begin
					n = count;
					roll_ofs = div_nearest(roll_ofs, n);
					pitch_ofs = div_nearest(pitch_ofs, n);
					roll_bias = div_nearest(roll_bias, n);
					pitch_bias = div_nearest(pitch_bias, n);
					yaw_bias = div_nearest(yaw_bias, n);
					calibrated = 1;
					roll_ang = 0;
					pitch_ang = 0;
					yaw_ang = 0;
				end
			end else begin
				dz = longint'(deadzone) <<< (FRAC - 8);
				rr = sat41(rr - roll_bias);
				pr = sat41(pr - pitch_bias);
				yr = sat41(yr - yaw_bias);
				roll_ang = blend(roll_ang, rr, roll_acc - roll_ofs);
				pitch_ang = blend(pitch_ang, pr, pitch_acc - pitch_ofs);
				if (yr > dz || yr < -dz)
					yaw_ang = sat32(yaw_ang + rnd_shift(yr * longint'(period), 16));
			end
			e.roll = roll_ang[31:0];
			e.pitch = pitch_ang[31:0];
			e.yaw = yaw_ang[31:0];
			e.cal = calibrated;
			pending.push_back(e);
		endfunction

		function void check(attitude_t got);
			attitude_t e;
			if (pending.size() == 0) begin
				$display("%t: attitude beat with none expected: roll %0d pitch %0d yaw %0d",
					$time, got.roll, got.pitch, got.yaw);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.roll !== e.roll) begin
				$display("%t: roll expected %0d actual %0d", $time, e.roll, got.roll);
				errors++;
			end
			if (got.pitch !== e.pitch) begin
				$display("%t: pitch expected %0d actual %0d", $time, e.pitch, got.pitch);
				errors++;
			end
			if (got.yaw !== e.yaw) begin
				$display("%t: yaw expected %0d actual %0d", $time, e.yaw, got.yaw);
				errors++;
			end
			if (got.cal !== e.cal) begin
				$display("%t: is_calibrated expected %0b actual %0b", $time, e.cal, got.cal);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	icf_sample_if smp();
	icf_attitude_if att();

	attitude_scoreboard sb = new();
	bit quiet_sender = 0;
	bit quiet_receiver = 0;
	bit long_hold = 0;

	imu_complementary_attitude i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(smp.sink),
		.attitude(att.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		smp.valid = 1'b0;
		{smp.accel_x, smp.accel_y, smp.accel_z} = '0;
		{smp.gyro_x, smp.gyro_y, smp.gyro_z} = '0;
		att.ready = 1'b0;
	end

	task automatic write_reg(logic [2:0] idx, int unsigned v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_W'({idx, 2'b00});
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_sample(imu_sample_t s);
		int gap;
		gap = quiet_sender ? 0 : $urandom_range(0, 17);
		repeat (gap) begin
			@(negedge clk);
			smp.valid = 1'b0;
		end
		@(negedge clk);
		smp.valid = 1'b1;
		smp.accel_x = s.ax;
		smp.accel_y = s.ay;
		smp.accel_z = s.az;
		smp.gyro_x = s.gx;
		smp.gyro_y = s.gy;
		smp.gyro_z = s.gz;
		do @(posedge clk); while (!smp.ready);
		sb.note(s);
	endtask

	// Drops valid and waits until every expected attitude beat has come.
	task automatic drain();
		@(negedge clk);
		smp.valid = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic imu_sample_t make_sample(logic signed [15:0] ax, ay, az, gx, gy, gz);
		imu_sample_t s;
		s.ax = ax;
		s.ay = ay;
		s.az = az;
		s.gx = gx;
		s.gy = gy;
		s.gz = gz;
		return s;
	endfunction

	// Mostly a sensor near level with small rates; the rest is full-range noise.
	function automatic imu_sample_t random_sample();
		imu_sample_t s;
		if ($urandom_range(0, 9) < 3) begin
			s = make_sample(16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			s.ax = 16'($signed($urandom_range(0, 8000)) - 4000);
			s.ay = 16'($signed($urandom_range(0, 8000)) - 4000);
			s.az = 16'(16384 + $signed($urandom_range(0, 4000)) - 2000);
			s.gx = 16'($signed($urandom_range(0, 1200)) - 600);
			s.gy = 16'($signed($urandom_range(0, 1200)) - 600);
			s.gz = 16'($signed($urandom_range(0, 1200)) - 600);
		end
		return s;
	endfunction

	task automatic random_phase(int n, int unsigned a, p, g, d);
		drain();
		write_reg(REG_ALPHA, a);
		write_reg(REG_PERIOD, p);
		write_reg(REG_GYRO_SENS, g);
		write_reg(REG_DEADZONE, d);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				quiet_sender = $urandom_range(0, 3) == 0;
				quiet_receiver = $urandom_range(0, 3) == 0;
			end
			send_sample(random_sample());
		end
	endtask

	initial begin : stimulus
		imu_sample_t dir[$];
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A limit above the maximum acts as the maximum, so calibration keeps going.
		write_reg(REG_CAL_SAMPLES, 2047);
		write_reg(REG_ALPHA, 0);
		write_reg(REG_PERIOD, 65535);
		write_reg(REG_GYRO_SENS, 1);
		write_reg(REG_DEADZONE, 0);
		dir.push_back(make_sample(0, 0, 0, 0, 0, 0));
		dir.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
		dir.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
		dir.push_back(make_sample(100, -50, -16000, 1, -1, 0));
		dir.push_back(make_sample(-100, 50, -16000, -1, 1, 5));
		dir.push_back(make_sample(0, 300, 0, 0, 0, 0));
		dir.push_back(make_sample(0, -300, -1, 0, 0, 0));
		dir.push_back(make_sample(-32768, 0, 0, 20, -20, 3));
		foreach (dir[i])
			send_sample(dir[i]);
		drain();
		// A zero limit acts as one: the next sample ends calibration early.
		write_reg(REG_CAL_SAMPLES, 0);
		dir.delete();
		dir.push_back(make_sample(10, -10, 16384, 5, -5, 7));
		dir.push_back(make_sample(0, 0, 16384, 0, 0, 0));
		dir.push_back(make_sample(32767, -32768, 0, 32767, -32768, 32767));
		dir.push_back(make_sample(-32768, 32767, -32768, -32768, 32767, -32768));
		dir.push_back(make_sample(0, 0, 0, 0, 0, 0));
		foreach (dir[i])
			send_sample(dir[i]);
		drain();
		write_reg(REG_CAL_SAMPLES, 1024);
		write_reg(REG_GYRO_SENS, 0);
		dir.delete();
		dir.push_back(make_sample(-5, 5, 16384, 2, -2, 1));
		dir.push_back(make_sample(-5, 5, 16384, -32768, 32767, -32768));
		dir.push_back(make_sample(-5, 5, 16384, 32767, -32768, 32767));
		foreach (dir[i])
			send_sample(dir[i]);

		random_phase(100, ALPHA_RST, PERIOD_RST, GYRO_SENS_RST, DEADZONE_RST);
		long_hold = 1;
		random_phase(100, 65535, 1, 65535, 65535);
		random_phase(100, $urandom_range(0, 65535), $urandom_range(1, 65535),
			$urandom_range(1, 65535), $urandom_range(0, 2000));
		random_phase(50, 62915, 65535, 1, 0);
		random_phase(80, $urandom_range(0, 65535), $urandom_range(1, 4000),
			$urandom_range(100, 65535), $urandom_range(0, 65535));

		drain();
		repeat (600) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("imu_complementary_attitude test passed");
		end else begin
			$display("imu_complementary_attitude test failed");
		end
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off so the block backs up.
	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 0;
				@(negedge clk);
				att.ready = 1'b0;
				repeat (1500) @(negedge clk);
			end
			gap = quiet_receiver ? 0 : $urandom_range(0, 17);
			repeat (gap) begin
				@(negedge clk);
				att.ready = 1'b0;
			end
			@(negedge clk);
			att.ready = 1'b1;
			do @(posedge clk); while (!att.valid);
		end
	end

	always @(posedge clk) begin
		attitude_t got;
		if (att.valid && att.ready) begin
			got.roll = att.roll_deg;
			got.pitch = att.pitch_deg;
			got.yaw = att.yaw_deg;
			got.cal = att.is_calibrated;
			sb.check(got);
		end
	end

	initial begin : watchdog
		#20ms;
		$display("imu_complementary_attitude test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/icf_pkg.sv
design/icf_if.sv
design/icf_mul.sv
design/icf_div.sv
design/icf_sqrt.sv
design/icf_cordic.sv
design/imu_complementary_attitude.sv
test/tb_top.sv
